@@ rtl/rrsg_pkg.sv @@
// Package: shared types and constants of the random ramp stimulus generator.
`default_nettype none

package rrsg_pkg;

  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_RAMP  = 2'd1,
    PH_CELL  = 2'd2,
    PH_WAIT  = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    CFG_RATE_MIN = 3'd0,
    CFG_RATE_MAX = 3'd1,
    CFG_INT_MIN  = 3'd2,
    CFG_INT_MAX  = 3'd3,
    CFG_VMAX     = 3'd4,
    CFG_TICK     = 3'd5
  } cfg_idx_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic [15:0] RateMinRst = 16'd256;
  localparam logic [15:0] RateMaxRst = 16'd5120;
  localparam logic [31:0] IntMinRst  = 32'd500000;
  localparam logic [31:0] IntMaxRst  = 32'd2000000;
  localparam logic [23:0] VmaxRst    = 24'd9000000;
  localparam logic [15:0] TickRst    = 16'd100;

  typedef struct packed {
    logic [15:0] rate_min_q8;
    logic [15:0] rate_max_q8;
    logic [31:0] interval_min_us;
    logic [31:0] interval_max_us;
    logic [23:0] vmax_uv;
    logic [15:0] tick_us;
  } cfg_t;

  typedef struct packed {
    logic        spike_active;
    logic [15:0] rate_draw;
    logic [15:0] interval_draw;
  } item_t;

endpackage

`default_nettype wire

@@ rtl/rrsg_cfg_regs.sv @@
// Configuration register file of the random ramp stimulus generator.
`default_nettype none

module rrsg_cfg_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [rrsg_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [rrsg_pkg::CfgDataW-1:0]     cfg_data_i,
  output rrsg_pkg::cfg_t                    cfg_o
);
  import rrsg_pkg::*;

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rate_min_q8     <= RateMinRst;
      cfg_q.rate_max_q8     <= RateMaxRst;
      cfg_q.interval_min_us <= IntMinRst;
      cfg_q.interval_max_us <= IntMaxRst;
      cfg_q.vmax_uv         <= VmaxRst;
      cfg_q.tick_us         <= TickRst;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_RATE_MIN: cfg_q.rate_min_q8     <= cfg_data_i[15:0];
        CFG_RATE_MAX: cfg_q.rate_max_q8     <= cfg_data_i[15:0];
        CFG_INT_MIN:  cfg_q.interval_min_us <= cfg_data_i[31:0];
        CFG_INT_MAX:  cfg_q.interval_max_us <= cfg_data_i[31:0];
        CFG_VMAX:     cfg_q.vmax_uv         <= cfg_data_i[23:0];
        CFG_TICK:     cfg_q.tick_us         <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/rrsg_in_stage.sv @@
// Input register stage: holds one tick word ahead of the step logic.
`default_nettype none

module rrsg_in_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  rrsg_pkg::item_t in_item_i,
  output logic            item_valid_o,
  output rrsg_pkg::item_t item_o,
  input  logic            item_take_i
);
  import rrsg_pkg::*;

  logic  valid_q;
  item_t item_q;

  assign in_stall_o   = valid_q && !item_take_i;
  assign item_valid_o = valid_q;
  assign item_o       = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/rrsg_core.sv @@
// Step logic: phase state, age counter, slope and pause pick, ramp level and result register.
`default_nettype none

module rrsg_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  rrsg_pkg::cfg_t  cfg_i,
  input  logic            item_valid_i,
  input  rrsg_pkg::item_t item_i,
  output logic            item_take_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [23:0]     vout_uv_o,
  output logic [1:0]      phase_o
);
  import rrsg_pkg::*;

  phase_e      phase_q, phase_d;
  logic [31:0] age_q, age_d;
  logic [15:0] slope_q, slope_d;
  logic [31:0] pause_q, pause_d;
  logic [31:0] cut_q, cut_d;

  logic        out_valid_q;
  logic [23:0] vout_q, vout_d;
  logic [1:0]  res_phase_q;

  logic        out_ready;
  logic [32:0] age_sum;
  logic [31:0] age_t;
  logic [15:0] rate_span;
  logic [31:0] rate_prod;
  logic [15:0] slope_pick;
  logic [31:0] int_span;
  logic [47:0] int_prod;
  logic [31:0] pause_pick;
  logic [47:0] level_prod;
  logic [39:0] level;
  logic        over;
  logic [31:0] gone;

  assign out_ready   = !out_valid_q || !out_stall_i;
  assign item_take_o = item_valid_i && out_ready;
  assign out_valid_o = out_valid_q;
  assign vout_uv_o   = vout_q;
  assign phase_o     = res_phase_q;

  always_comb begin
    age_sum    = {1'b0, age_q} + {17'b0, cfg_i.tick_us};
    age_t      = age_sum[32] ? 32'hFFFF_FFFF : age_sum[31:0];

    rate_span  = cfg_i.rate_max_q8 - cfg_i.rate_min_q8;
    rate_prod  = {16'b0, rate_span} * {16'b0, item_i.rate_draw};
    slope_pick = (cfg_i.rate_max_q8 <= cfg_i.rate_min_q8) ? cfg_i.rate_min_q8
                 : cfg_i.rate_min_q8 + rate_prod[31:16];

    int_span   = cfg_i.interval_max_us - cfg_i.interval_min_us;
    int_prod   = {16'b0, int_span} * {32'b0, item_i.interval_draw};
    pause_pick = (cfg_i.interval_max_us <= cfg_i.interval_min_us) ? cfg_i.interval_min_us
                 : cfg_i.interval_min_us + int_prod[47:16];

    level_prod = {32'b0, slope_q} * {16'b0, age_t};
    level      = level_prod[47:8];
    over       = level > {16'b0, cfg_i.vmax_uv};

    gone       = (age_t >= cut_q) ? age_t - cut_q : 32'd0;

    phase_d = phase_q;
    age_d   = age_t;
    slope_d = slope_q;
    pause_d = pause_q;
    cut_d   = cut_q;
    vout_d  = 24'd0;

    case (phase_q)
      PH_START: begin
        slope_d = slope_pick;
        pause_d = pause_pick;
        age_d   = 32'd0;
        phase_d = PH_RAMP;
      end
      PH_RAMP: begin
        if (item_i.spike_active) begin
          phase_d = PH_CELL;
        end else if (over) begin
          cut_d   = age_t;
          phase_d = PH_WAIT;
        end else begin
          vout_d = level[23:0];
        end
      end
      PH_CELL: begin
        if (!item_i.spike_active) begin
          cut_d   = age_t;
          phase_d = PH_WAIT;
        end
      end
      PH_WAIT: begin
        if (gone > pause_q) begin
          phase_d = PH_START;
        end
      end
      default: phase_d = PH_START;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_START;
      age_q       <= 32'd0;
      slope_q     <= 16'd0;
      pause_q     <= 32'd0;
      cut_q       <= 32'd0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= item_take_o || (out_valid_q && out_stall_i);
      if (item_take_o) begin
        phase_q <= phase_d;
        age_q   <= age_d;
        slope_q <= slope_d;
        pause_q <= pause_d;
        cut_q   <= cut_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_take_o) begin
      vout_q      <= vout_d;
      res_phase_q <= phase_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/random_ramp_stimulus_generator.sv @@
// Top level of the random ramp stimulus generator.
//
// Input channel (in_valid_i / in_stall_o): one word per sample tick, carrying
// the spike flag and two 16-bit uniform draws used when a new ramp starts.
// Output channel (out_valid_o / out_stall_i): one word per input word, with
// the ramp level in microvolts and the phase after the tick.
// Config channel (cfg_valid_i / cfg_ready_o): register index and data; always
// ready. The user must write it only while no tick is in flight; not enforced.
// From input accept to output valid, a word passes an input register, then
// the step logic (three multiplies and compares) into the result register.
// Throughput is one word per cycle while the receiver does not stall; the
// phase and age registers load at the same edge as the result register.
// Reset puts the block in the start phase with zero age and loads the
// default limits. When the receiver stalls, the result word holds, one more
// tick waits in the input register, and then in_stall_o rises.
`default_nettype none

module random_ramp_stimulus_generator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          spike_active_i,
  input  logic [15:0]                   rate_draw_i,
  input  logic [15:0]                   interval_draw_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [23:0]                   vout_uv_o,
  output logic [1:0]                    phase_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rrsg_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [rrsg_pkg::CfgDataW-1:0] cfg_data_i
);
  import rrsg_pkg::*;

  cfg_t  cfg;
  item_t in_item;
  item_t item;
  logic  item_valid;
  logic  item_take;

  assign in_item.spike_active  = spike_active_i;
  assign in_item.rate_draw     = rate_draw_i;
  assign in_item.interval_draw = interval_draw_i;

  rrsg_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  rrsg_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_item_i    (in_item),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_take_i  (item_take)
  );

  rrsg_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_take_o  (item_take),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .vout_uv_o    (vout_uv_o),
    .phase_o      (phase_o)
  );

endmodule

`default_nettype wire

@@ rtl/rrsg_checker.sv @@
// Port-level checker for the random ramp stimulus generator, with its bind.
`default_nettype none

module rrsg_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_stall_o,
  input  logic        out_valid_o,
  input  logic        out_stall_i,
  input  logic [23:0] vout_uv_o,
  input  logic [1:0]  phase_o
);
  import rrsg_pkg::*;

  logic       have_last_q;
  logic [1:0] last_phase_q;
  logic       out_acc;

  assign out_acc = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_last_q  <= 1'b0;
      last_phase_q <= PH_START;
    end else if (out_acc) begin
      have_last_q  <= 1'b1;
      last_phase_q <= phase_o;
    end
  end

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(vout_uv_o) && $stable(phase_o))
    else $error("stalled output word changed");

  a_no_back_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled while output drains");

  a_level_in_ramp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && vout_uv_o != 24'd0 |-> phase_o == PH_RAMP)
    else $error("nonzero level outside ramp phase");

  a_start_to_ramp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && have_last_q && last_phase_q == PH_START |-> phase_o == PH_RAMP)
    else $error("start not followed by ramp");

  a_cell_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && have_last_q && last_phase_q == PH_CELL
      |-> phase_o == PH_CELL || phase_o == PH_WAIT)
    else $error("wait-for-cell left to wrong phase");

endmodule

bind random_ramp_stimulus_generator rrsg_checker u_rrsg_checker (.*);

`default_nettype wire
